/* sv/bcc_pkg.sv */
// Shared types, constants and helper functions for the button click classifier.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package bcc_pkg;

  localparam int unsigned CntWidth    = 16;
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CmpWidth    = (CntWidth > CfgWidth) ? CntWidth : CfgWidth;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned EventWidth  = 2;

  typedef logic [CntWidth-1:0]    cnt_t;
  typedef logic [CfgWidth-1:0]    cfg_val_t;
  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;
  typedef logic [EventWidth-1:0]  event_t;

  localparam event_t EvNone   = 2'd0;
  localparam event_t EvShort  = 2'd1;
  localparam event_t EvDouble = 2'd2;
  localparam event_t EvLong   = 2'd3;

  typedef struct packed {
    cfg_val_t press_threshold;
    cfg_val_t long_press_threshold;
    cfg_val_t release_threshold;
    cfg_val_t done_threshold;
    cfg_val_t unstable_timeout;
    cfg_val_t sticky_timeout;
  } cfg_t;

  typedef struct packed {
    event_t event_res;
    logic   active;
  } res_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == '1) ? v : cnt_t'(v + cnt_t'(1));
  endfunction

  function automatic logic exceeds(cnt_t v, cfg_val_t thr);
    return CmpWidth'(v) > CmpWidth'(thr);
  endfunction

endpackage

`default_nettype wire

/* sv/bcc_ifs.sv */
// Valid/ready channel interfaces for the button click classifier: sample input,
// result output and configuration writes. Depends on bcc_pkg.
`default_nettype none

interface bcc_in_if;
  import bcc_pkg::*;
  logic valid;
  logic ready;
  logic pressed;
  modport source (output valid, output pressed, input ready);
  modport sink (input valid, input pressed, output ready);
endinterface

interface bcc_out_if;
  import bcc_pkg::*;
  logic   valid;
  logic   ready;
  event_t event_res;
  logic   active;
  modport source (output valid, output event_res, output active, input ready);
  modport sink (input valid, input event_res, input active, output ready);
endinterface

interface bcc_cfg_if;
  import bcc_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  cfg_val_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/bcc_cfg_regs.sv */
// Configuration register file of the button click classifier.
// Depends on bcc_pkg and the bcc_cfg_if interface.
`default_nettype none

module bcc_cfg_regs (
  input  wire            clk_i,
  input  wire            rst_ni,
  bcc_cfg_if.sink        cfg_i,
  output bcc_pkg::cfg_t  cfg_o
);
  import bcc_pkg::*;

  localparam cfg_idx_t RegPress    = 3'd0;
  localparam cfg_idx_t RegLong     = 3'd1;
  localparam cfg_idx_t RegRelease  = 3'd2;
  localparam cfg_idx_t RegDone     = 3'd3;
  localparam cfg_idx_t RegUnstable = 3'd4;
  localparam cfg_idx_t RegSticky   = 3'd5;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        RegPress:    cfg_d.press_threshold      = cfg_i.data;
        RegLong:     cfg_d.long_press_threshold = cfg_i.data;
        RegRelease:  cfg_d.release_threshold    = cfg_i.data;
        RegDone:     cfg_d.done_threshold       = cfg_i.data;
        RegUnstable: cfg_d.unstable_timeout     = cfg_i.data;
        RegSticky:   cfg_d.sticky_timeout       = cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_threshold      <= cfg_val_t'(3);
      cfg_q.long_press_threshold <= cfg_val_t'(1000);
      cfg_q.release_threshold    <= cfg_val_t'(3);
      cfg_q.done_threshold       <= cfg_val_t'(50);
      cfg_q.unstable_timeout     <= cfg_val_t'(100);
      cfg_q.sticky_timeout       <= cfg_val_t'(5000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

/* sv/bcc_fsm.sv */
// Debounce and click classification state machine with its run and elapsed counters.
// Computes one result per step from the registered sample. Depends on bcc_pkg.
`default_nettype none

module bcc_fsm (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            step_i,
  input  wire            pressed_i,
  input  bcc_pkg::cfg_t  cfg_i,
  output bcc_pkg::res_t  res_o
);
  import bcc_pkg::*;

  localparam logic [2:0] ModeIdle     = 3'd0;
  localparam logic [2:0] ModeDebounce = 3'd1;
  localparam logic [2:0] ModePressed  = 3'd2;
  localparam logic [2:0] ModeReleased = 3'd3;
  localparam logic [2:0] ModeLongRel  = 3'd4;

  logic [2:0] mode_q, mode_d, mode_eff;
  cnt_t       pressed_run_q, pressed_run_d, pr0;
  cnt_t       released_run_q, released_run_d, rr0;
  cnt_t       elapsed_q, elapsed_d;
  cnt_t       pr_cnt, rr_cnt;
  event_t     ev;
  logic       start;

  always_comb begin
    start    = (mode_q == ModeIdle) && pressed_i;
    mode_eff = start ? ModeDebounce : mode_q;
    pr0      = start ? '0 : pressed_run_q;
    rr0      = start ? '0 : released_run_q;
    if (mode_q == ModeIdle) begin
      elapsed_d = start ? '0 : elapsed_q;
    end else begin
      elapsed_d = sat_inc(elapsed_q);
    end
    pr_cnt = pressed_i ? sat_inc(pr0) : pr0;
    rr_cnt = pressed_i ? rr0 : sat_inc(rr0);

    ev             = EvNone;
    mode_d         = mode_eff;
    pressed_run_d  = pr0;
    released_run_d = rr0;

    case (mode_eff)
      ModeIdle: begin
      end
      ModeDebounce: begin
        pressed_run_d  = pressed_i ? pr_cnt : '0;
        released_run_d = pressed_i ? '0 : rr_cnt;
        if (exceeds(pressed_run_d, cfg_i.press_threshold)) begin
          mode_d = ModePressed;
        end else if (exceeds(elapsed_d, cfg_i.unstable_timeout)) begin
          mode_d = ModeIdle;
        end
      end
      ModePressed: begin
        pressed_run_d  = pr_cnt;
        released_run_d = rr_cnt;
        if (exceeds(pr_cnt, cfg_i.long_press_threshold)) begin
          ev     = EvLong;
          mode_d = ModeLongRel;
        end else if (exceeds(rr_cnt, cfg_i.release_threshold)) begin
          pressed_run_d  = '0;
          released_run_d = '0;
          mode_d         = ModeReleased;
        end
      end
      ModeReleased: begin
        pressed_run_d  = pr_cnt;
        released_run_d = rr_cnt;
        if (exceeds(rr_cnt, cfg_i.done_threshold)) begin
          ev     = (pr_cnt == '0) ? EvShort : EvDouble;
          mode_d = ModeIdle;
        end
      end
      ModeLongRel: begin
        pressed_run_d  = pr_cnt;
        released_run_d = rr_cnt;
        if (exceeds(rr_cnt, cfg_i.release_threshold) ||
            exceeds(elapsed_d, cfg_i.sticky_timeout)) begin
          mode_d = ModeIdle;
        end
      end
      default: begin
        mode_d = ModeIdle;
      end
    endcase

    res_o.event_res = ev;
    res_o.active    = (mode_d != ModeIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= ModeIdle;
      pressed_run_q  <= '0;
      released_run_q <= '0;
      elapsed_q      <= '0;
    end else if (step_i) begin
      mode_q         <= mode_d;
      pressed_run_q  <= pressed_run_d;
      released_run_q <= released_run_d;
      elapsed_q      <= elapsed_d;
    end
  end

endmodule

`default_nettype wire

/* sv/button_click_classifier.sv */
// Button click classifier top level: input register, classifier step and result register.
// An input transfer is held in the input register, then the step loads the result register;
// one sample per cycle is taken unless a full result register is stalled by out_o.ready.
// Reset returns the classifier to idle with cleared counters and loads the default
// thresholds; both channel stages come out of reset empty.
`default_nettype none

module button_click_classifier (
  input  wire      clk_i,
  input  wire      rst_ni,
  bcc_in_if.sink   in_i,
  bcc_out_if.source out_o,
  bcc_cfg_if.sink  cfg_i
);
  import bcc_pkg::*;

  logic in_valid_q;
  logic in_pressed_q;
  logic out_valid_q;
  res_t out_res_q;
  res_t step_res;
  cfg_t cfg;
  logic advance;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  assign out_o.valid     = out_valid_q;
  assign out_o.event_res = out_res_q.event_res;
  assign out_o.active    = out_res_q.active;

  bcc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bcc_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .pressed_i (in_pressed_q),
    .cfg_i     (cfg),
    .res_o     (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_pressed_q <= in_i.pressed;
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  // A short press or double click always ends monitoring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_res_q.event_res == EvShort || out_res_q.event_res == EvDouble)
    |-> !out_res_q.active)
    else $error("click event reported while monitoring stays active");

  // A long press always leaves monitoring active for the release phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.event_res == EvLong |-> out_res_q.active)
    else $error("long press reported without active monitoring");

  // A full input stage behind a stalled result must hold off new transfers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_o.ready |-> !in_i.ready && !advance)
    else $error("input taken while both stages are full and stalled");

  // Every step loads the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("classifier step produced no result");

endmodule

`default_nettype wire
